FILE: rtl/vvs_pkg.sv
// ----------------------------------------------------------------------------
// vvs_pkg
// Shared widths, codes and item types of the velocity Verlet step unit.
// ----------------------------------------------------------------------------
package vvs_pkg;

  // Field widths
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TS_W   = 32;

  // Stream and register port widths
  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Internal datapath widths
  localparam int unsigned MAG_W   = 33;  // |a| or |a0 + a1|, up to 2^32
  localparam int unsigned PROD_W  = 64;  // MAG * dt, below 2^64
  localparam int unsigned HMAG_W  = 40;  // rounded half kick magnitude
  localparam int unsigned HDV_W   = 41;  // signed half kick
  localparam int unsigned VMID_W  = 42;  // signed vmid and velocity sum
  localparam int unsigned VMAG_W  = 40;  // |vmid|
  localparam int unsigned HI_W    = VMAG_W - WORD_W;
  localparam int unsigned HIP_W   = HI_W + TS_W;
  localparam int unsigned FULL_W  = VMAG_W + TS_W;
  localparam int unsigned RX_W    = FULL_W - 24;
  localparam int unsigned XW_W    = 50;  // position sum before clipping

  // Rounding shifts (Q16.16 * Q8.24 back to Q16.16, with and without /2)
  localparam int unsigned HALF_SH = 25;
  localparam int unsigned STEP_SH = 24;
  localparam logic [PROD_W:0]   HALF_RND = (PROD_W + 1)'(1) << (HALF_SH - 1);
  localparam logic [FULL_W-1:0] STEP_RND = FULL_W'(1) << (STEP_SH - 1);

  // Commands carried in tuser
  typedef enum logic [0:0] {
    CMD_KICK_DRIFT = 1'b0,
    CMD_CORRECT    = 1'b1
  } cmd_e;

  // Register index (paddr word select)
  typedef enum logic [0:0] {
    REG_TIME_STEP = 1'b0
  } reg_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] accel;
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] pos;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] pos;
    logic                     sat;
  } out_item_t;

  // One saved entry per element
  typedef struct packed {
    logic signed [WORD_W-1:0] vel;
    logic signed [WORD_W-1:0] acc;
  } state_word_t;

  typedef struct packed {
    logic                     clip;
    logic signed [WORD_W-1:0] val;
  } sat_t;

  // Clip a wide signed value to 32 bits
  function automatic sat_t sat_word(input logic signed [XW_W-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[WORD_W-1:0];
    if (!v[XW_W-1] && (|v[XW_W-2:WORD_W-1])) begin
      r.clip = 1'b1;
      r.val  = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v[XW_W-1] && !(&v[XW_W-2:WORD_W-1])) begin
      r.clip = 1'b1;
      r.val  = {1'b1, {(WORD_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/vvs_cfg_regs.sv
// ----------------------------------------------------------------------------
// vvs_cfg_regs
// Register port: holds the time step, written and read over the APB-style bus.
// ----------------------------------------------------------------------------
module vvs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [vvs_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [vvs_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [vvs_pkg::PDATA_W-1:0]   prdata_o,
  output logic                          pready_o,
  output logic [vvs_pkg::TS_W-1:0]      time_step_o
);

  logic [vvs_pkg::TS_W-1:0] time_step_q;
  vvs_pkg::reg_e            reg_sel;
  logic                     wr_hit;

  assign pready_o    = 1'b1;
  assign reg_sel     = vvs_pkg::reg_e'(paddr_i[2]);
  assign wr_hit      = psel_i & penable_i & pwrite_i & pready_o
                     & (reg_sel == vvs_pkg::REG_TIME_STEP);
  assign time_step_o = time_step_q;

  // Write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
    end else if (wr_hit) begin
      time_step_q <= pwdata_i[vvs_pkg::TS_W-1:0];
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      vvs_pkg::REG_TIME_STEP: prdata_o = time_step_q;
      default:                prdata_o = '0;
    endcase
  end

endmodule

FILE: rtl/vvs_state_mem.sv
// ----------------------------------------------------------------------------
// vvs_state_mem
// Per-element store of saved velocity and acceleration, registered read.
// ----------------------------------------------------------------------------
module vvs_state_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        addr_i,
  input  vvs_pkg::state_word_t wdata_i,
  output vvs_pkg::state_word_t rdata_o
);

  vvs_pkg::state_word_t mem_q [DEPTH];
  vvs_pkg::state_word_t rdata_q;

  // Entries stay undefined until stage one writes them
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/vvs_pipe.sv
// ----------------------------------------------------------------------------
// vvs_pipe
// Eight-stage arithmetic pipeline plus output register. Stage one computes
// the half kick, vmid and drift; stage two the velocity correction.
// ----------------------------------------------------------------------------
module vvs_pipe #(
  parameter int unsigned VECTOR_DEPTH = 64,
  parameter int unsigned AW           = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vvs_pkg::TS_W-1:0]    time_step_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vvs_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vvs_pkg::out_item_t          out_item_o,
  output logic                        mem_we_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_addr_o,
  output vvs_pkg::state_word_t        mem_wdata_o,
  input  vvs_pkg::state_word_t        mem_rdata_i
);

  localparam int unsigned NST = 8;

  // --------------------------------------------------------------------------
  // Flow control: each stage loads when empty or when the next one loads
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic [NST-1:0] rdy;
  logic           out_vld_q;
  logic           rdy_out;
  logic           acc;
  logic           in_range;

  always_comb begin
    rdy_out      = ~out_vld_q | out_ready_i;
    rdy[NST-1]   = ~vld_q[NST-1] | rdy_out;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign acc         = in_valid_i & rdy[0];
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (rdy_out) begin
        out_vld_q <= vld_q[NST-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // State store access: write on stage-one items, read with every S1 load
  // --------------------------------------------------------------------------
  assign in_range      = 32'(in_item_i.idx) < 32'(VECTOR_DEPTH);
  assign mem_we_o      = acc & (in_item_i.cmd == vvs_pkg::CMD_KICK_DRIFT) & in_range;
  assign mem_re_o      = rdy[0];
  assign mem_addr_o    = AW'(in_item_i.idx);
  assign mem_wdata_o.vel = in_item_i.vel;
  assign mem_wdata_o.acc = in_item_i.accel;

  // --------------------------------------------------------------------------
  // S1: input capture
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s1_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s1_idx_q;
  logic                               s1_inr_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s1_a_q, s1_v_q, s1_x_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_cmd_q <= in_item_i.cmd;
      s1_idx_q <= in_item_i.idx;
      s1_inr_q <= in_range;
      s1_a_q   <= in_item_i.accel;
      s1_v_q   <= in_item_i.vel;
      s1_x_q   <= in_item_i.pos;
    end
  end

  // Kick operand (a or a0 + a1), its sign and magnitude; velocity base
  logic signed [vvs_pkg::MAG_W-1:0]   a0e_d, a1e_d, m1_d;
  logic        [vvs_pkg::MAG_W-1:0]   mag1_d;
  logic signed [vvs_pkg::WORD_W-1:0]  base1_d;
  logic                               neg1_d;

  always_comb begin
    a1e_d = {s1_a_q[vvs_pkg::WORD_W-1], s1_a_q};
    a0e_d = s1_inr_q ? {mem_rdata_i.acc[vvs_pkg::WORD_W-1], mem_rdata_i.acc} : '0;
    if (s1_cmd_q == vvs_pkg::CMD_CORRECT) begin
      m1_d    = a0e_d + a1e_d;
      base1_d = s1_inr_q ? mem_rdata_i.vel : '0;
    end else begin
      m1_d    = a1e_d;
      base1_d = s1_v_q;
    end
    neg1_d = m1_d[vvs_pkg::MAG_W-1];
    mag1_d = neg1_d ? vvs_pkg::MAG_W'(-m1_d) : vvs_pkg::MAG_W'(m1_d);
  end

  // --------------------------------------------------------------------------
  // S2: multiply |operand| by dt
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s2_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s2_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s2_x_q, s2_base_q;
  logic                               s2_neg_q;
  logic [vvs_pkg::MAG_W-1:0]          s2_mag_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_idx_q  <= s1_idx_q;
      s2_x_q    <= s1_x_q;
      s2_base_q <= base1_d;
      s2_neg_q  <= neg1_d;
      s2_mag_q  <= mag1_d;
    end
  end

  logic [vvs_pkg::MAG_W+vvs_pkg::TS_W-1:0] prod2_d;
  assign prod2_d = s2_mag_q * time_step_i;

  // --------------------------------------------------------------------------
  // S3: round to nearest (ties away), restore sign
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s3_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s3_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s3_x_q, s3_base_q;
  logic                               s3_neg_q;
  logic [vvs_pkg::PROD_W-1:0]         s3_prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_idx_q  <= s2_idx_q;
      s3_x_q    <= s2_x_q;
      s3_base_q <= s2_base_q;
      s3_neg_q  <= s2_neg_q;
      s3_prod_q <= prod2_d[vvs_pkg::PROD_W-1:0];
    end
  end

  logic [vvs_pkg::PROD_W:0]          rsum3_d;
  logic [vvs_pkg::HMAG_W-1:0]        rmag3_d;
  logic signed [vvs_pkg::HDV_W-1:0]  hdv3_d;

  always_comb begin
    rsum3_d = {1'b0, s3_prod_q} + vvs_pkg::HALF_RND;
    rmag3_d = rsum3_d[vvs_pkg::PROD_W:vvs_pkg::HALF_SH];
    hdv3_d  = s3_neg_q ? -$signed({1'b0, rmag3_d}) : $signed({1'b0, rmag3_d});
  end

  // --------------------------------------------------------------------------
  // S4: vmid = base + half kick
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s4_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s4_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s4_x_q, s4_base_q;
  logic signed [vvs_pkg::HDV_W-1:0]   s4_hdv_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_idx_q  <= s3_idx_q;
      s4_x_q    <= s3_x_q;
      s4_base_q <= s3_base_q;
      s4_hdv_q  <= hdv3_d;
    end
  end

  logic signed [vvs_pkg::VMID_W-1:0] hdv4_ext, vmid4_d;

  always_comb begin
    hdv4_ext = {s4_hdv_q[vvs_pkg::HDV_W-1], s4_hdv_q};
    vmid4_d  = hdv4_ext
             + {{(vvs_pkg::VMID_W-vvs_pkg::WORD_W){s4_base_q[vvs_pkg::WORD_W-1]}}, s4_base_q};
  end

  // --------------------------------------------------------------------------
  // S5: |vmid| for the drift, final velocity sum
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s5_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s5_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s5_x_q;
  logic signed [vvs_pkg::VMID_W-1:0]  s5_vmid_q, s5_hdv_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_cmd_q  <= s4_cmd_q;
      s5_idx_q  <= s4_idx_q;
      s5_x_q    <= s4_x_q;
      s5_vmid_q <= vmid4_d;
      s5_hdv_q  <= hdv4_ext;
    end
  end

  logic                               vneg5_d;
  logic signed [vvs_pkg::VMID_W-1:0]  vabs5_d, vout5_d;

  always_comb begin
    vneg5_d = s5_vmid_q[vvs_pkg::VMID_W-1];
    vabs5_d = vneg5_d ? -s5_vmid_q : s5_vmid_q;
    // stage one: v' = vmid + hdv; stage two: v' = v0 + hdv, already in vmid
    vout5_d = (s5_cmd_q == vvs_pkg::CMD_KICK_DRIFT) ? s5_vmid_q + s5_hdv_q : s5_vmid_q;
  end

  // --------------------------------------------------------------------------
  // S6: |vmid| * dt as two partial products
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s6_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s6_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s6_x_q;
  logic                               s6_vneg_q;
  logic [vvs_pkg::VMAG_W-1:0]         s6_vmag_q;
  logic signed [vvs_pkg::VMID_W-1:0]  s6_vout_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_cmd_q  <= s5_cmd_q;
      s6_idx_q  <= s5_idx_q;
      s6_x_q    <= s5_x_q;
      s6_vneg_q <= vneg5_d;
      s6_vmag_q <= vabs5_d[vvs_pkg::VMAG_W-1:0];
      s6_vout_q <= vout5_d;
    end
  end

  logic [vvs_pkg::PROD_W-1:0] lo6_d;
  logic [vvs_pkg::HIP_W-1:0]  hi6_d;

  assign lo6_d = s6_vmag_q[vvs_pkg::WORD_W-1:0] * time_step_i;
  assign hi6_d = s6_vmag_q[vvs_pkg::VMAG_W-1:vvs_pkg::WORD_W] * time_step_i;

  // --------------------------------------------------------------------------
  // S7: combine partial products and round the drift
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s7_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s7_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s7_x_q;
  logic                               s7_vneg_q;
  logic [vvs_pkg::PROD_W-1:0]         s7_lo_q;
  logic [vvs_pkg::HIP_W-1:0]          s7_hi_q;
  logic signed [vvs_pkg::VMID_W-1:0]  s7_vout_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_cmd_q  <= s6_cmd_q;
      s7_idx_q  <= s6_idx_q;
      s7_x_q    <= s6_x_q;
      s7_vneg_q <= s6_vneg_q;
      s7_lo_q   <= lo6_d;
      s7_hi_q   <= hi6_d;
      s7_vout_q <= s6_vout_q;
    end
  end

  logic [vvs_pkg::FULL_W-1:0] full7_d;

  assign full7_d = {{(vvs_pkg::FULL_W-vvs_pkg::PROD_W){1'b0}}, s7_lo_q}
                 + {s7_hi_q, {vvs_pkg::WORD_W{1'b0}}}
                 + vvs_pkg::STEP_RND;

  // --------------------------------------------------------------------------
  // S8: position sum, clipping, result assembly
  // --------------------------------------------------------------------------
  vvs_pkg::cmd_e                      s8_cmd_q;
  logic [vvs_pkg::IDX_W-1:0]          s8_idx_q;
  logic signed [vvs_pkg::WORD_W-1:0]  s8_x_q;
  logic                               s8_vneg_q;
  logic [vvs_pkg::RX_W-1:0]           s8_rx_q;
  logic signed [vvs_pkg::VMID_W-1:0]  s8_vout_q;

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_cmd_q  <= s7_cmd_q;
      s8_idx_q  <= s7_idx_q;
      s8_x_q    <= s7_x_q;
      s8_vneg_q <= s7_vneg_q;
      s8_rx_q   <= full7_d[vvs_pkg::FULL_W-1:vvs_pkg::STEP_SH];
      s8_vout_q <= s7_vout_q;
    end
  end

  logic signed [vvs_pkg::XW_W-1:0] xe8, rxe8, xw8_d, vw8_d;
  vvs_pkg::sat_t                   vsat8, xsat8;
  vvs_pkg::out_item_t              res8_d;

  always_comb begin
    xe8   = {{(vvs_pkg::XW_W-vvs_pkg::WORD_W){s8_x_q[vvs_pkg::WORD_W-1]}}, s8_x_q};
    rxe8  = {{(vvs_pkg::XW_W-vvs_pkg::RX_W){1'b0}}, s8_rx_q};
    xw8_d = s8_vneg_q ? xe8 - rxe8 : xe8 + rxe8;
    vw8_d = {{(vvs_pkg::XW_W-vvs_pkg::VMID_W){s8_vout_q[vvs_pkg::VMID_W-1]}}, s8_vout_q};
    vsat8 = vvs_pkg::sat_word(vw8_d);
    xsat8 = vvs_pkg::sat_word(xw8_d);
    res8_d.idx = s8_idx_q;
    res8_d.vel = vsat8.val;
    case (s8_cmd_q)
      vvs_pkg::CMD_KICK_DRIFT: begin
        res8_d.pos = xsat8.val;
        res8_d.sat = vsat8.clip | xsat8.clip;
      end
      vvs_pkg::CMD_CORRECT: begin
        res8_d.pos = s8_x_q;
        res8_d.sat = vsat8.clip;
      end
      default: begin
        res8_d.pos = s8_x_q;
        res8_d.sat = vsat8.clip;
      end
    endcase
  end

  // Output register
  vvs_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_q <= res8_d;
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: rtl/velocity_verlet_step_unit.sv
// ----------------------------------------------------------------------------
// velocity_verlet_step_unit
// Fixed-point velocity Verlet integrator, one vector element per item.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid / tready           tdata: element, a, v, x
//                                                  tuser: command
//   m_axis    out        tvalid / tready           tdata: element, v', x'
//                                                  tuser: saturated
//   apb       in/out     psel, penable, pready     time_step at address 0
//
// One item per cycle sustained while m_axis_tready stays high. The edge that
// accepts an item loads it into the first of eight pipeline stages (the
// 40x32 drift product is split over two of them); the item then moves
// through the stages in order, and the last stage loads the output register.
// Reset clears the valid bits and the time step; the element store is not
// cleared and holds undefined data until stage one writes an entry.
// With m_axis_tready low the output holds, empty stages keep filling, and
// s_axis_tready drops only when every stage is occupied.
// ----------------------------------------------------------------------------
module velocity_verlet_step_unit #(
  parameter int unsigned VECTOR_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Item input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] element_index, [37:6] acceleration, [69:38] velocity_in,
  // [101:70] position_in, [103:102] zero
  input  logic [vvs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] command
  input  logic [0:0]                        s_axis_tuser,
  // Result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] element_out, [37:6] velocity_out, [69:38] position_out, [71:70] zero
  output logic [vvs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] saturated
  output logic [0:0]                        m_axis_tuser,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vvs_pkg::PADDR_W-1:0]       paddr,
  input  logic [vvs_pkg::PDATA_W-1:0]       pwdata,
  output logic [vvs_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [vvs_pkg::TS_W-1:0] time_step;
  vvs_pkg::in_item_t        in_item;
  vvs_pkg::out_item_t       out_item;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_addr;
  vvs_pkg::state_word_t     mem_wdata, mem_rdata;

  // Unpack input item
  assign in_item.cmd   = vvs_pkg::cmd_e'(s_axis_tuser[0]);
  assign in_item.idx   = s_axis_tdata[5:0];
  assign in_item.accel = s_axis_tdata[37:6];
  assign in_item.vel   = s_axis_tdata[69:38];
  assign in_item.pos   = s_axis_tdata[101:70];

  // Pack result item
  assign m_axis_tdata    = {2'b00, out_item.pos, out_item.vel, out_item.idx};
  assign m_axis_tuser[0] = out_item.sat;

  vvs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready),
    .time_step_o (time_step)
  );

  vvs_state_mem #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  vvs_pipe #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .AW           (AW)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .time_step_i (time_step),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

endmodule

FILE: rtl/vvs_checker.sv
// ----------------------------------------------------------------------------
// vvs_checker
// Port-level checks of the velocity Verlet step unit, bound to the top level.
// ----------------------------------------------------------------------------
module vvs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vvs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                    m_axis_tuser,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [vvs_pkg::PADDR_W-1:0]   paddr,
  input logic [vvs_pkg::PDATA_W-1:0]   pwdata,
  input logic [vvs_pkg::PDATA_W-1:0]   prdata
);

  // No result is offered in the cycle after reset is seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A ready sink never throttles the input side
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with ready sink");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // Time step reads back what was written
  a_ts_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[2] == vvs_pkg::REG_TIME_STEP) |=>
      (paddr[2] != vvs_pkg::REG_TIME_STEP || prdata == $past(pwdata)))
    else $error("time step readback mismatch");

endmodule

bind velocity_verlet_step_unit vvs_checker u_vvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

FILE: tb/velocity_verlet_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_verlet_step_unit_tb
// Self-checking bench for the fixed-point velocity Verlet step unit.
//
// Elements are fed as kick/drift and correction items over the input stream.
// Every accepted item is run through a bit-exact integrator kept here, and
// each returned result is checked field by field in arrival order. The time
// step register is rewritten between phases while the unit is drained, and
// each write is read back. Stalls and gaps are applied on both streams,
// including one long output stall that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module velocity_verlet_step_unit_tb;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned LATENCY    = 9;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned REPORT_MAX = 50;
  localparam logic [127:0] PROD_CLAMP = 128'h1_0000_0000_0000;  // 2^48
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // DUT inputs, known from time zero
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic [vvs_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]                    s_axis_tuser  = '0;
  logic                          m_axis_tready = 1'b0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [vvs_pkg::PADDR_W-1:0]   paddr         = '0;
  logic [vvs_pkg::PDATA_W-1:0]   pwdata        = '0;

  logic                          s_axis_tready;
  logic                          m_axis_tvalid;
  logic [vvs_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic [vvs_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  velocity_verlet_step_unit #(
    .VECTOR_DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Integrator state mirrored on the bench side
  logic [vvs_pkg::TS_W-1:0]          step_size = '0;
  logic signed [vvs_pkg::WORD_W-1:0] kick_vel [DEPTH];
  logic signed [vvs_pkg::WORD_W-1:0] kick_acc [DEPTH];
  bit                                stored   [DEPTH];

  vvs_pkg::in_item_t  pending_items[$];
  vvs_pkg::out_item_t expected_results[$];
  vvs_pkg::in_item_t  offered_item;
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // round(m * d / 2^sh), ties away from zero, magnitudes clamped at 2^48
  function automatic longint round_scaled(input longint m,
                                          input logic [vvs_pkg::TS_W-1:0] d,
                                          input int unsigned sh);
    logic [127:0] mag;
    logic [127:0] prod;
    logic         neg;
    longint       res;
    neg = (m < 0);
    mag = neg ? 128'(-m) : 128'(m);
    if (mag > PROD_CLAMP) mag = PROD_CLAMP;
    prod = (mag * d + (128'(1) << (sh - 1))) >> sh;
    if (prod > PROD_CLAMP) prod = PROD_CLAMP;
    res = prod[63:0];
    return neg ? -res : res;
  endfunction

  // {clipped, value} of a wide sum squeezed into a signed word
  function automatic logic [vvs_pkg::WORD_W:0] clip_word(input longint v);
    if (v > WORD_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < WORD_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[vvs_pkg::WORD_W-1:0]};
  endfunction

  // One integrator step; a kick/drift item also stores v and a for the element
  function automatic vvs_pkg::out_item_t integrate_element(input vvs_pkg::in_item_t it);
    vvs_pkg::out_item_t       r;
    longint                   a, v, x, v0, a0, half_kick, vmid;
    logic [vvs_pkg::WORD_W:0] cv, cx;
    a = it.accel;
    v = it.vel;
    x = it.pos;
    if (it.cmd == vvs_pkg::CMD_KICK_DRIFT) begin
      half_kick = round_scaled(a, step_size, vvs_pkg::HALF_SH);
      vmid = v + half_kick;
      kick_vel[it.idx] = it.vel;
      kick_acc[it.idx] = it.accel;
      cv = clip_word(vmid + half_kick);
      cx = clip_word(x + round_scaled(vmid, step_size, vvs_pkg::STEP_SH));
    end else begin
      v0 = kick_vel[it.idx];
      a0 = kick_acc[it.idx];
      cv = clip_word(v0 + round_scaled(a0 + a, step_size, vvs_pkg::HALF_SH));
      cx = {1'b0, it.pos};
    end
    r.idx = it.idx;
    r.vel = cv[vvs_pkg::WORD_W-1:0];
    r.pos = cx[vvs_pkg::WORD_W-1:0];
    r.sat = cv[vvs_pkg::WORD_W] | cx[vvs_pkg::WORD_W];
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Item driver: holds valid until taken, predicts at acceptance
  always @(posedge clk_i) begin : item_driver
    logic offer;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(integrate_element(offered_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (pending_items.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          offered_item = pending_items.pop_front();
          s_axis_tdata <= {2'b00, offered_item.pos, offered_item.vel,
                           offered_item.accel, offered_item.idx};
          s_axis_tuser <= offered_item.cmd;
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // Result side ready: random idling, plus long holds on request
  always @(posedge clk_i) begin : result_ready
    logic ready_next;
    if (hold_served != hold_requests) begin
      hold_left = HOLD_LEN;
      hold_served++;
    end
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = ($urandom_range(99) >= recv_idle_pct);
    end
    m_axis_tready <= ready_next;
  end

  // Result monitor
  always @(posedge clk_i) begin : result_check
    vvs_pkg::out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = expected_results.pop_front();
        check_field("element_out", 32'(want.idx), 32'(m_axis_tdata[5:0]));
        check_field("velocity_out", want.vel, m_axis_tdata[37:6]);
        check_field("position_out", want.pos, m_axis_tdata[69:38]);
        check_field("saturated", 32'(want.sat), 32'(m_axis_tuser[0]));
      end
    end
  end

  // Wait until nothing is queued, offered or outstanding
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Register write (setup + access), then a read back
  task automatic write_time_step(input logic [vvs_pkg::TS_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {vvs_pkg::REG_TIME_STEP, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    step_size = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    check_field("time_step readback", val, prdata);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain, let the pipeline settle, then set up the next phase
  task automatic start_phase(input logic [vvs_pkg::TS_W-1:0] dt,
                             input int unsigned send_pct,
                             input int unsigned recv_pct);
    wait_drained();
    repeat (LATENCY) @(negedge clk_i);
    write_time_step(dt);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic queue_item(input vvs_pkg::cmd_e c, input logic [vvs_pkg::IDX_W-1:0] e,
                            input logic [31:0] a, input logic [31:0] v,
                            input logic [31:0] x);
    vvs_pkg::in_item_t it;
    it.cmd   = c;
    it.idx   = e;
    it.accel = a;
    it.vel   = v;
    it.pos   = x;
    pending_items.push_back(it);
    if (c == vvs_pkg::CMD_KICK_DRIFT) stored[e] = 1'b1;
  endtask

  // Mix of extremes, small physical values and full-range words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly kick bursts followed by their corrections; some lone items as noise
  task automatic queue_random(input int unsigned count);
    int unsigned                made;
    int unsigned                len;
    int unsigned                k;
    logic [vvs_pkg::IDX_W-1:0]  burst[$];
    logic [vvs_pkg::IDX_W-1:0]  e;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        e = $urandom_range(DEPTH - 1);
        // a correction only ever targets an element that has been kicked
        if (stored[e] && $urandom_range(1))
          queue_item(vvs_pkg::CMD_CORRECT, e, rand_word(), rand_word(), rand_word());
        else
          queue_item(vvs_pkg::CMD_KICK_DRIFT, e, rand_word(), rand_word(), rand_word());
        made++;
      end else begin
        len = $urandom_range(8, 1);
        burst.delete();
        repeat (len) begin
          e = $urandom_range(DEPTH - 1);
          burst.push_back(e);
          queue_item(vvs_pkg::CMD_KICK_DRIFT, e, rand_word(), rand_word(), rand_word());
        end
        while (burst.size() != 0) begin
          k = $urandom_range(burst.size() - 1);
          queue_item(vvs_pkg::CMD_CORRECT, burst[k], rand_word(), rand_word(),
                     rand_word());
          burst.delete(k);
        end
        made += 2 * len;
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: dt = 1.0, field extremes, both stages, rounding ties.
    // Elements past the store depth cannot be addressed with a 6-bit index,
    // and the value ranges keep products below the wide clamp.
    start_phase(32'h0100_0000, 10, 81);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd0,  32'h0000_0000, 32'h0000_0000,
               32'h0000_0000);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd1,  32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd2,  32'h0000_0001, 32'hFFFF_FFFF,
               32'h0000_0001);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd3,  32'hFFFF_FFFF, 32'h0000_0001,
               32'hFFFF_FFFF);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd42, 32'h0001_0000, 32'h0001_0000,
               32'h0000_0000);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd21, 32'hFFFE_0000, 32'h0000_8000,
               32'h7FFF_0000);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd0,  32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h1234_5678);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd63, 32'h7FFF_FFFF, 32'h0000_0000,
               32'h8000_0000);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd1,  32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd2,  32'h0000_0000, 32'h0000_0000,
               32'h0000_0000);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd3,  32'hFFFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd42, 32'h0002_0000, 32'h0001_0000,
               32'h0000_0000);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd21, 32'h0003_0000, 32'h0000_0000,
               32'h0000_0001);
    // re-read of a stored element, then overwrite and read again
    queue_item(vvs_pkg::CMD_CORRECT,    6'd63, 32'h8000_0000, 32'h5555_5555,
               32'hAAAA_AAAA);
    queue_item(vvs_pkg::CMD_KICK_DRIFT, 6'd63, 32'hAAAA_AAAA, 32'h5555_5555,
               32'h5555_5555);
    queue_item(vvs_pkg::CMD_CORRECT,    6'd63, 32'h5555_5555, 32'hAAAA_AAAA,
               32'hAAAA_AAAA);

    // Random phases over several time steps, extremes included
    queue_random(180);
    start_phase(32'hFFFF_FFFF, 10, 81);
    queue_random(180);
    start_phase(32'h0000_0001, 81, 10);
    queue_random(180);
    start_phase(32'h0000_0000, 81, 10);
    queue_random(180);
    // long output hold while the input keeps offering: the pipeline backs up
    start_phase(32'h0002_8F5C, 0, 0);
    queue_random(180);
    hold_requests++;
    start_phase($urandom(), 0, 0);
    queue_random(180);

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
